>>> sv/spsf_pkg.sv
// Shared types, constants and lookup functions of the stipple pattern stroke finder.
package spsf_pkg;

    localparam int MAX_SIDE_DEF = 16;
    localparam int CFG_W        = 5;
    localparam int HALF_TURN    = 1800;
    localparam int RIGHT_ANGLE  = 900;
    localparam int CORDIC_STEPS = 20;
    localparam int STEP_W       = 5;
    localparam int FRAC_BITS    = 16;
    localparam int COORD_BITS   = 24;
    localparam int VEC_W        = 36;
    localparam int ANG_ACC_W    = 32;
    localparam int ANGLE_W      = 11;
    localparam int SPACING_W    = 5;
    localparam int WALK_W       = 3;
    localparam int LAST_WALKER  = 7;

    // Step codes along x: two's complement -1, 0, +1.
    localparam logic [1:0] DX_ZERO = 2'b00;
    localparam logic [1:0] DX_POS  = 2'b01;
    localparam logic [1:0] DX_NEG  = 2'b11;

    typedef struct packed {
        logic       bottom;   // paths start along the bottom edge, else the left edge
        logic [1:0] dx1;
        logic       dy1;
        logic [1:0] dx2;
        logic       dy2;
    } walker_t;

    typedef enum logic [11:0] {
        ST_LOAD   = 12'b0000_0000_0001,
        ST_WINIT  = 12'b0000_0000_0010,
        ST_SCAN   = 12'b0000_0000_0100,
        ST_DECIDE = 12'b0000_0000_1000,
        ST_DIV    = 12'b0000_0001_0000,
        ST_CSET   = 12'b0000_0010_0000,
        ST_CITER  = 12'b0000_0100_0000,
        ST_CFIN   = 12'b0000_1000_0000,
        ST_ACCEPT = 12'b0001_0000_0000,
        ST_EMITP  = 12'b0010_0000_0000,
        ST_NEXTW  = 12'b0100_0000_0000,
        ST_FINAL  = 12'b1000_0000_0000
    } state_t;

    typedef enum logic [1:0] {
        PH_INIT = 2'd0,
        PH_DIR1 = 2'd1,
        PH_DIR2 = 2'd2
    } phase_t;

    function automatic walker_t walker_dirs(input logic [WALK_W-1:0] k);
        walker_t w;
        unique case (k)
            3'd0:    w = '{1'b0, DX_POS,  1'b0, DX_POS,  1'b1};
            3'd1:    w = '{1'b0, DX_POS,  1'b1, DX_POS,  1'b0};
            3'd2:    w = '{1'b1, DX_POS,  1'b1, DX_ZERO, 1'b1};
            3'd3:    w = '{1'b1, DX_ZERO, 1'b1, DX_POS,  1'b1};
            3'd4:    w = '{1'b1, DX_ZERO, 1'b1, DX_NEG,  1'b1};
            3'd5:    w = '{1'b1, DX_NEG,  1'b1, DX_ZERO, 1'b1};
            3'd6:    w = '{1'b0, DX_NEG,  1'b1, DX_NEG,  1'b0};
            default: w = '{1'b0, DX_NEG,  1'b0, DX_NEG,  1'b1};
        endcase
        return w;
    endfunction

    // atan(2^-i) in tenths of a degree with 16 fraction bits
    function automatic logic signed [ANG_ACC_W-1:0] atan_step(input logic [STEP_W-1:0] i);
        logic signed [ANG_ACC_W-1:0] a;
        unique case (i)
            5'd0:    a = 32'sd29491200;
            5'd1:    a = 32'sd17409672;
            5'd2:    a = 32'sd9198793;
            5'd3:    a = 32'sd4669451;
            5'd4:    a = 32'sd2343786;
            5'd5:    a = 32'sd1173036;
            5'd6:    a = 32'sd586661;
            5'd7:    a = 32'sd293348;
            5'd8:    a = 32'sd146676;
            5'd9:    a = 32'sd73339;
            5'd10:   a = 32'sd36669;
            5'd11:   a = 32'sd18335;
            5'd12:   a = 32'sd9167;
            5'd13:   a = 32'sd4584;
            5'd14:   a = 32'sd2292;
            5'd15:   a = 32'sd1146;
            5'd16:   a = 32'sd573;
            5'd17:   a = 32'sd286;
            5'd18:   a = 32'sd143;
            5'd19:   a = 32'sd72;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

>>> sv/stipple_pattern_stroke_finder.sv
// Top level of the stipple pattern stroke finder: bitmap store, walker sequencer, CORDIC.
//
// Usage:
//   s_ channel: one pixel per transfer (s_tdata[0]), s_tlast on the final pixel of a pattern.
//   Pixels arrive top row first; one pixel is taken every cycle while loading.
//   cfg channel: pattern side (1..16); user writes it only while block is idle, unchecked.
//   m_ channel: one transfer per stroke, m_tlast on the last result of a pattern;
//   m_tuser[0] low marks the marker for a pattern with no stroke (angle and spacing zero).
// Processing:
//   After the last pixel each of the eight walkers runs an init scan and up to two
//   scans per step over s steps; each scan issues one store read per path, registers
//   the read data, then decides. A walker that completes all steps then runs the spacing
//   division and, unless its offset is horizontal, the CORDIC (20 iterations plus setup
//   and rounding). The store read port sets the pace.
//   s_tready stays low from the last pixel until the final result is in the output register.
// Reset: side returns to 1, the sequencer returns to loading, pixel count and seen flags
//   clear. The bitmap store is not cleared.
// Stall: a single output register holds a result; while m_tready is low and the register
//   is full the sequencer waits before placing the next result.
module stipple_pattern_stroke_finder
    import spsf_pkg::*;
#(
    parameter int MAX_SIDE = MAX_SIDE_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,   // [0] pixel_bit, [7:1] zero
    input  logic             s_tlast,   // last_pixel
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [15:0]      m_tdata,   // [10:0] stroke_angle, [15:11] stroke_spacing
    output logic [0:0]       m_tuser,   // [0] stroke_valid
    output logic             m_tlast,   // last_stroke
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CFG_W-1:0] cfg_data   // pattern_side
);

    localparam int SW    = $clog2(MAX_SIDE + 1);
    localparam int CW    = $clog2(MAX_SIDE);
    localparam int DEPTH = MAX_SIDE * MAX_SIDE;
    localparam int AW    = $clog2(DEPTH);
    localparam int PCW   = $clog2(DEPTH + 1);
    localparam int OW    = SW + 1;

    // Bitmap store
    logic mem [DEPTH];
    logic mem_we;
    logic [AW-1:0] rd_addr;
    logic rd_data_reg;

    // Configuration and load state
    logic [CFG_W-1:0] side_cfg_reg, side_cfg_next;
    logic [SW-1:0]    s_used;
    logic [CW-1:0]    s_last_idx;
    logic [PCW-1:0]   s_sq;
    logic [PCW-1:0]   pix_cnt_reg, pix_cnt_next;
    logic             seen_one_reg, seen_one_next, seen_zero_reg, seen_zero_next;
    logic             in_xfer, one_now, zero_now;

    // Sequencer
    state_t           state_reg, state_next;
    phase_t           phase_reg, phase_next;
    logic [WALK_W-1:0] walker_reg, walker_next;
    walker_t          wd;
    logic [CW-1:0]    step_reg, step_next;
    logic [CW-1:0]    iss_reg, iss_next;
    logic             iss_done_reg, iss_done_next;
    logic             cap_vld_reg, cap_vld_next;
    logic [CW-1:0]    cap_idx_reg, cap_idx_next;
    logic [MAX_SIDE-1:0] active_reg, active_next, na_reg, na_next;
    logic [SW-1:0]    cnt_reg, cnt_next;
    logic             cap_bit;

    // Walker position: wrapped offset and plain offset of path 0
    logic [CW-1:0]    wx_reg, wx_next, wy_reg, wy_next;
    logic signed [OW-1:0] ox_reg, ox_next, oy_reg, oy_next;
    logic [1:0]       ph_dx;
    logic             ph_dy;
    logic [CW-1:0]    cand_wx, cand_wy, lane_wrap, cx, cy, row;
    logic [CW:0]      lane_sum;

    // Spacing division
    logic signed [OW-1:0] rem_reg, rem_next, rem_diff;
    logic [SW-1:0]    q_reg, q_next;

    // CORDIC
    logic signed [VEC_W-1:0] vx_reg, vx_next, vy_reg, vy_next;
    logic signed [VEC_W-1:0] xsh, ymag, ysh;
    logic signed [ANG_ACC_W-1:0] z_reg, z_next, zc, zr;
    logic [STEP_W-1:0] it_reg, it_next;
    logic signed [OW-1:0] cx_in, cy_in;
    logic [ANGLE_W-1:0] ang_reg, ang_next;

    // Stroke bookkeeping
    logic [ANGLE_W-1:0]   pend_ang_reg, pend_ang_next, first_reg, first_next;
    logic [ANGLE_W-1:0]   prev_reg, prev_next;
    logic [SPACING_W-1:0] pend_spc_reg, pend_spc_next;
    logic                 have_reg, have_next, accept_ok;

    // Output register
    logic                 out_vld_reg, out_vld_next, out_free;
    logic [ANGLE_W-1:0]   out_ang_reg, out_ang_next;
    logic [SPACING_W-1:0] out_spc_reg, out_spc_next;
    logic                 out_user_reg, out_user_next, out_last_reg, out_last_next;

    assign s_tready  = (state_reg == ST_LOAD);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_vld_reg;
    assign m_tdata   = {out_spc_reg, out_ang_reg};
    assign m_tuser   = out_user_reg;
    assign m_tlast   = out_last_reg;

    // Clamp the side register into 1..MAX_SIDE
    always_comb begin
        if (side_cfg_reg == '0) begin
            s_used = SW'(1);
        end else if (int'(side_cfg_reg) > MAX_SIDE) begin
            s_used = SW'(MAX_SIDE);
        end else begin
            s_used = SW'(side_cfg_reg);
        end
    end
    assign s_last_idx = CW'(s_used - SW'(1));
    assign s_sq       = PCW'(PCW'(s_used) * PCW'(s_used));

    assign in_xfer  = s_tvalid && s_tready;
    assign one_now  = seen_one_reg | s_tdata[0];
    assign zero_now = seen_zero_reg | ~s_tdata[0];
    assign mem_we   = in_xfer && (pix_cnt_reg < s_sq);

    // Direction of the current scan
    assign wd = walker_dirs(walker_reg);
    always_comb begin
        unique case (phase_reg)
            PH_DIR1: begin
                ph_dx = wd.dx1;
                ph_dy = wd.dy1;
            end
            PH_DIR2: begin
                ph_dx = wd.dx2;
                ph_dy = wd.dy2;
            end
            default: begin
                ph_dx = DX_ZERO;
                ph_dy = 1'b0;
            end
        endcase
    end

    // Candidate wrapped offset and store address of path iss_reg
    always_comb begin
        unique case (ph_dx)
            DX_POS:  cand_wx = (wx_reg == s_last_idx) ? '0 : wx_reg + CW'(1);
            DX_NEG:  cand_wx = (wx_reg == '0) ? s_last_idx : wx_reg - CW'(1);
            default: cand_wx = wx_reg;
        endcase
        if (ph_dy) begin
            cand_wy = (wy_reg == s_last_idx) ? '0 : wy_reg + CW'(1);
        end else begin
            cand_wy = wy_reg;
        end
        lane_sum  = {1'b0, (wd.bottom ? cand_wx : cand_wy)} + {1'b0, iss_reg};
        lane_wrap = (lane_sum >= (CW+1)'(s_used)) ? CW'(lane_sum - (CW+1)'(s_used))
                                                  : CW'(lane_sum);
        cx        = wd.bottom ? lane_wrap : cand_wx;
        cy        = wd.bottom ? cand_wy : lane_wrap;
        row       = s_last_idx - cy;
        rd_addr   = AW'(AW'(row) * AW'(s_used) + AW'(cx));
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[pix_cnt_reg[AW-1:0]] <= s_tdata[0];
        end
        rd_data_reg <= mem[rd_addr];
    end

    // CORDIC datapath: shifted x, magnitude shift for the negative y branch, angle clamp and rounding
    always_comb begin
        xsh  = vx_reg >>> it_reg;
        ymag = (vy_reg < 0) ? -vy_reg : vy_reg;
        ysh  = (vy_reg < 0) ? -(ymag >>> it_reg) : (ymag >>> it_reg);
        zc   = z_reg;
        if (z_reg < 0) begin
            zc = '0;
        end else if (z_reg > (ANG_ACC_W'(HALF_TURN) <<< FRAC_BITS)) begin
            zc = ANG_ACC_W'(HALF_TURN) <<< FRAC_BITS;
        end
        zr = zc + (ANG_ACC_W'(1) <<< (FRAC_BITS - 1));
    end

    assign rem_diff  = rem_reg - $signed({1'b0, cnt_reg});
    assign cap_bit   = rd_data_reg & ((phase_reg == PH_INIT) | active_reg[cap_idx_reg]);
    assign out_free  = !out_vld_reg || m_tready;
    assign accept_ok = !have_reg || ((ang_reg != prev_reg) &&
                       ({1'b0, ang_reg} != ({1'b0, first_reg} + 12'(HALF_TURN))));

    always_comb begin
        side_cfg_next  = side_cfg_reg;
        state_next     = state_reg;
        phase_next     = phase_reg;
        walker_next    = walker_reg;
        step_next      = step_reg;
        iss_next       = iss_reg;
        iss_done_next  = iss_done_reg;
        cap_vld_next   = 1'b0;
        cap_idx_next   = cap_idx_reg;
        active_next    = active_reg;
        na_next        = na_reg;
        cnt_next       = cnt_reg;
        wx_next        = wx_reg;
        wy_next        = wy_reg;
        ox_next        = ox_reg;
        oy_next        = oy_reg;
        rem_next       = rem_reg;
        q_next         = q_reg;
        vx_next        = vx_reg;
        vy_next        = vy_reg;
        z_next         = z_reg;
        it_next        = it_reg;
        ang_next       = ang_reg;
        pend_ang_next  = pend_ang_reg;
        pend_spc_next  = pend_spc_reg;
        first_next     = first_reg;
        prev_next      = prev_reg;
        have_next      = have_reg;
        pix_cnt_next   = pix_cnt_reg;
        seen_one_next  = seen_one_reg;
        seen_zero_next = seen_zero_reg;
        out_vld_next   = m_tready ? 1'b0 : out_vld_reg;
        out_ang_next   = out_ang_reg;
        out_spc_next   = out_spc_reg;
        out_user_next  = out_user_reg;
        out_last_next  = out_last_reg;
        cx_in          = ox_reg;
        cy_in          = oy_reg;

        if (cfg_valid) begin
            side_cfg_next = cfg_data;
        end

        unique case (state_reg)
            ST_LOAD: begin
                if (in_xfer) begin
                    if (pix_cnt_reg < PCW'(DEPTH)) begin
                        pix_cnt_next = pix_cnt_reg + PCW'(1);
                    end
                    seen_one_next  = one_now;
                    seen_zero_next = zero_now;
                    if (s_tlast) begin
                        pix_cnt_next   = '0;
                        seen_one_next  = 1'b0;
                        seen_zero_next = 1'b0;
                        if (!one_now) begin
                            have_next  = 1'b0;
                            state_next = ST_FINAL;
                        end else if (!zero_now) begin
                            // solid pattern: one stroke, angle 0, spacing 1
                            pend_ang_next = '0;
                            pend_spc_next = SPACING_W'(1);
                            have_next     = 1'b1;
                            state_next    = ST_FINAL;
                        end else begin
                            have_next   = 1'b0;
                            walker_next = '0;
                            state_next  = ST_WINIT;
                        end
                    end
                end
            end
            ST_WINIT: begin
                wx_next       = '0;
                wy_next       = '0;
                ox_next       = '0;
                oy_next       = '0;
                step_next     = '0;
                phase_next    = PH_INIT;
                iss_next      = '0;
                iss_done_next = 1'b0;
                cnt_next      = '0;
                na_next       = '0;
                state_next    = ST_SCAN;
            end
            ST_SCAN: begin
                // issue one path read a cycle, fold in the registered read data
                if (!iss_done_reg) begin
                    cap_vld_next = 1'b1;
                    cap_idx_next = iss_reg;
                    if (iss_reg == s_last_idx) begin
                        iss_done_next = 1'b1;
                    end else begin
                        iss_next = iss_reg + CW'(1);
                    end
                end
                if (cap_vld_reg) begin
                    na_next[cap_idx_reg] = cap_bit;
                    cnt_next = cnt_reg + SW'(cap_bit);
                end
                if (iss_done_reg && !cap_vld_reg) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                iss_next      = '0;
                iss_done_next = 1'b0;
                cnt_next      = '0;
                na_next       = '0;
                if (phase_reg == PH_INIT) begin
                    active_next = na_reg;
                    phase_next  = PH_DIR1;
                    state_next  = ST_SCAN;
                end else if (cnt_reg != '0) begin
                    // commit the step: all paths move by the same offset
                    active_next = na_reg;
                    wx_next     = cand_wx;
                    wy_next     = cand_wy;
                    ox_next     = ox_reg + {{(OW-2){ph_dx[1]}}, ph_dx};
                    oy_next     = oy_reg + {{(OW-1){1'b0}}, ph_dy};
                    if (step_reg == s_last_idx) begin
                        cnt_next   = cnt_reg;
                        rem_next   = $signed({1'b0, s_used});
                        q_next     = '0;
                        state_next = ST_DIV;
                    end else begin
                        step_next  = step_reg + CW'(1);
                        phase_next = PH_DIR1;
                        state_next = ST_SCAN;
                    end
                end else if (phase_reg == PH_DIR1) begin
                    phase_next = PH_DIR2;
                    state_next = ST_SCAN;
                end else begin
                    state_next = ST_NEXTW;
                end
            end
            ST_DIV: begin
                // ceil(side / survivors) by repeated subtraction
                q_next   = q_reg + SW'(1);
                rem_next = rem_diff;
                if (rem_diff <= 0) begin
                    state_next = ST_CSET;
                end
            end
            ST_CSET: begin
                if (oy_reg == '0) begin
                    ang_next   = (ox_reg < 0) ? ANGLE_W'(HALF_TURN) : '0;
                    state_next = ST_ACCEPT;
                end else begin
                    z_next = '0;
                    if (ox_reg <= 0) begin
                        cx_in  = oy_reg;
                        cy_in  = -ox_reg;
                        z_next = ANG_ACC_W'(RIGHT_ANGLE) <<< FRAC_BITS;
                    end
                    vx_next    = {{(VEC_W-OW){cx_in[OW-1]}}, cx_in} <<< COORD_BITS;
                    vy_next    = {{(VEC_W-OW){cy_in[OW-1]}}, cy_in} <<< COORD_BITS;
                    it_next    = '0;
                    state_next = ST_CITER;
                end
            end
            ST_CITER: begin
                if (vy_reg >= 0) begin
                    vx_next = vx_reg + ysh;
                    vy_next = vy_reg - xsh;
                    z_next  = z_reg + atan_step(it_reg);
                end else begin
                    vx_next = vx_reg - ysh;
                    vy_next = vy_reg + xsh;
                    z_next  = z_reg - atan_step(it_reg);
                end
                if (it_reg == STEP_W'(CORDIC_STEPS - 1)) begin
                    state_next = ST_CFIN;
                end else begin
                    it_next = it_reg + STEP_W'(1);
                end
            end
            ST_CFIN: begin
                // clamp to a half turn, round half up
                ang_next   = zr[FRAC_BITS+ANGLE_W-1:FRAC_BITS];
                state_next = ST_ACCEPT;
            end
            ST_ACCEPT: begin
                if (!accept_ok) begin
                    state_next = ST_NEXTW;
                end else begin
                    prev_next = ang_reg;
                    if (!have_reg) begin
                        first_next    = ang_reg;
                        have_next     = 1'b1;
                        pend_ang_next = ang_reg;
                        pend_spc_next = SPACING_W'(q_reg);
                        state_next    = ST_NEXTW;
                    end else begin
                        state_next = ST_EMITP;
                    end
                end
            end
            ST_EMITP: begin
                // release the held stroke, hold the new one until we know if it is last
                if (out_free) begin
                    out_vld_next  = 1'b1;
                    out_ang_next  = pend_ang_reg;
                    out_spc_next  = pend_spc_reg;
                    out_user_next = 1'b1;
                    out_last_next = 1'b0;
                    pend_ang_next = ang_reg;
                    pend_spc_next = SPACING_W'(q_reg);
                    state_next    = ST_NEXTW;
                end
            end
            ST_NEXTW: begin
                if (walker_reg == WALK_W'(LAST_WALKER)) begin
                    state_next = ST_FINAL;
                end else begin
                    walker_next = walker_reg + WALK_W'(1);
                    state_next  = ST_WINIT;
                end
            end
            ST_FINAL: begin
                if (out_free) begin
                    out_vld_next  = 1'b1;
                    out_last_next = 1'b1;
                    out_user_next = have_reg;
                    out_ang_next  = have_reg ? pend_ang_reg : '0;
                    out_spc_next  = have_reg ? pend_spc_reg : '0;
                    have_next     = 1'b0;
                    state_next    = ST_LOAD;
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side_cfg_reg  <= CFG_W'(1);
            state_reg     <= ST_LOAD;
            phase_reg     <= PH_INIT;
            walker_reg    <= '0;
            step_reg      <= '0;
            iss_reg       <= '0;
            iss_done_reg  <= 1'b0;
            cap_vld_reg   <= 1'b0;
            cnt_reg       <= '0;
            it_reg        <= '0;
            have_reg      <= 1'b0;
            first_reg     <= '0;
            prev_reg      <= '0;
            pix_cnt_reg   <= '0;
            seen_one_reg  <= 1'b0;
            seen_zero_reg <= 1'b0;
            out_vld_reg   <= 1'b0;
        end else begin
            side_cfg_reg  <= side_cfg_next;
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            walker_reg    <= walker_next;
            step_reg      <= step_next;
            iss_reg       <= iss_next;
            iss_done_reg  <= iss_done_next;
            cap_vld_reg   <= cap_vld_next;
            cnt_reg       <= cnt_next;
            it_reg        <= it_next;
            have_reg      <= have_next;
            first_reg     <= first_next;
            prev_reg      <= prev_next;
            pix_cnt_reg   <= pix_cnt_next;
            seen_one_reg  <= seen_one_next;
            seen_zero_reg <= seen_zero_next;
            out_vld_reg   <= out_vld_next;
        end
        cap_idx_reg  <= cap_idx_next;
        active_reg   <= active_next;
        na_reg       <= na_next;
        wx_reg       <= wx_next;
        wy_reg       <= wy_next;
        ox_reg       <= ox_next;
        oy_reg       <= oy_next;
        rem_reg      <= rem_next;
        q_reg        <= q_next;
        vx_reg       <= vx_next;
        vy_reg       <= vy_next;
        z_reg        <= z_next;
        ang_reg      <= ang_next;
        pend_ang_reg <= pend_ang_next;
        pend_spc_reg <= pend_spc_next;
        out_ang_reg  <= out_ang_next;
        out_spc_reg  <= out_spc_next;
        out_user_reg <= out_user_next;
        out_last_reg <= out_last_next;
    end

`ifndef SYNTH
    a_marker_alone: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tlast && (m_tdata == '0))
        else $error("empty marker carries data or is not last");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DECIDE) |-> (cnt_reg <= s_used))
        else $error("survivor count exceeds pattern side");

    a_busy_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("input taken right after the last pixel");

    a_cordic_x_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CITER) |-> (vx_reg > 0))
        else $error("CORDIC x left the right half plane");
`endif

endmodule
